[hw/rtl/ccpe_pkg.sv]
package ccpe_pkg;

  // configuration register map
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_START    = 2'd0;
  localparam logic [IDX_W-1:0] REG_SHOULDER = 2'd1;
  localparam logic [IDX_W-1:0] REG_END      = 2'd2;
  localparam logic [IDX_W-1:0] REG_SHAPE    = 2'd3;

  // register and field widths
  localparam int CFG_W   = 60;
  localparam int SHAPE_W = 16;
  localparam int OUT_W   = 22;

  // shape factor after reset: one half
  localparam logic [SHAPE_W-1:0] SHAPE_RESET = 16'd32768;

endpackage

[hw/rtl/ccpe_sqrt_cell.sv]
// One digit of the square root: trial subtract of 2*R*2^j + 2^2j
module ccpe_sqrt_cell #(
  parameter int FB     = 16,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [2*FB+1:0]   rem_i,
  input  logic [FB:0]       root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [2*FB+1:0]   rem_o,
  output logic [FB:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW  = 2 * FB + 2;
  localparam int RTW = FB + 1;
  localparam logic [RTW-1:0] BIT = RTW'(1) << STEP;

  logic [RW-1:0]  trial;
  logic           hit;
  logic [RW-1:0]  rem_nxt;
  logic [RTW-1:0] root_nxt;
  logic           v_r;
  logic [RW-1:0]  rem_r;
  logic [RTW-1:0] root_r;
  logic [SIDE_W-1:0] side_r;

  // trial value and conditional subtract
  always_comb begin
    trial    = (RW'(root_i) << (STEP + 1)) | (RW'(1) << (2 * STEP));
    hit      = (rem_i >= trial);
    rem_nxt  = hit ? (rem_i - trial) : rem_i;
    root_nxt = hit ? (root_i | BIT) : root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

[hw/rtl/ccpe_div_cell.sv]
// One quotient bit of a restoring division
module ccpe_div_cell #(
  parameter int FB     = 16,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [2*FB+1:0]   rem_i,
  input  logic [FB+1:0]     den_i,
  input  logic [FB:0]       q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [2*FB+1:0]   rem_o,
  output logic [FB+1:0]     den_o,
  output logic [FB:0]       q_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NW = 2 * FB + 2;
  localparam int DW = FB + 2;
  localparam int QW = FB + 1;
  localparam logic [QW-1:0] BIT = QW'(1) << STEP;

  logic [NW-1:0] dsh;
  logic          hit;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;
  logic          v_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] q_r;
  logic [SIDE_W-1:0] side_r;

  // shifted divisor compare and subtract
  always_comb begin
    dsh     = NW'(den_i) << STEP;
    hit     = (rem_i >= dsh);
    rem_nxt = hit ? (rem_i - dsh) : rem_i;
    q_nxt   = hit ? (q_i | BIT) : q_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

[hw/rtl/ccpe_axis.sv]
// Per-axis blend: A + floor(dl*t/F) + floor(db*y0/2F), saturated
module ccpe_axis #(
  parameter int CB = 20,
  parameter int FB = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [FB:0]                    t_i,
  input  logic signed [FB+1:0]           y0_i,
  input  logic signed [CB-1:0]           a_i,
  input  logic signed [CB:0]             dl_i,
  input  logic signed [CB+1:0]           db_i,
  output logic [ccpe_pkg::OUT_W-1:0]     val_o
);

  localparam int OW   = ccpe_pkg::OUT_W;
  localparam int LW   = CB + FB + 3;
  localparam int BW   = CB + FB + 4;
  localparam int SUMW = (CB + FB + 5 > OW + 1) ? CB + FB + 5 : OW + 1;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((2 ** (OW - 1)) - 1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  logic signed [LW-1:0]   lin_nxt, lin_r;
  logic signed [BW-1:0]   bend_nxt, bend_r;
  logic signed [SUMW-1:0] lin_e, bend_e, a_e, sum;
  logic [OW-1:0]          val_nxt, val_r;

  // products
  always_comb begin
    lin_nxt  = dl_i * $signed({1'b0, t_i});
    bend_nxt = db_i * y0_i;
  end

  // floor shifts, sum and saturation
  always_comb begin
    lin_e  = SUMW'(lin_r);
    bend_e = SUMW'(bend_r);
    a_e    = SUMW'(a_i);
    sum    = a_e + (lin_e >>> FB) + (bend_e >>> (FB + 1));
    if (sum > SAT_HI) begin
      val_nxt = SAT_HI[OW-1:0];
    end else if (sum < SAT_LO) begin
      val_nxt = SAT_LO[OW-1:0];
    end else begin
      val_nxt = sum[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r  <= lin_nxt;
      bend_r <= bend_nxt;
      val_r  <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

[hw/rtl/conic_curve_point_evaluator.sv]
// Conic arc point evaluator, fully pipelined: one request per cycle while in_stall is low.
// 2*FRAC_BITS+11 register stages, among them FRAC_BITS+1 square root cells and
// FRAC_BITS+1 divider cells.
// A stalled output parks one result in a skid register; further input then stalls.
// Synchronous active-low reset clears all valid bits, the points to zero
// and the shape factor to one half.
module conic_curve_point_evaluator #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [FRAC_BITS:0]                in_param_t,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ccpe_pkg::OUT_W-1:0]        out_x_out,
  output logic [ccpe_pkg::OUT_W-1:0]        out_y_out,
  output logic [ccpe_pkg::OUT_W-1:0]        out_z_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccpe_pkg::IDX_W-1:0]        cfg_index,
  input  logic [ccpe_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int TW   = FB + 1;
  localparam int RW   = 2 * FB + 2;
  localparam int DW   = FB + 2;
  localparam int QW   = FB + 1;
  localparam int YW   = FB + 2;
  localparam int NUMW = 2 * FB;
  localparam int SQS  = TW + NUMW;
  localparam int CFW  = (FB + 1 > ccpe_pkg::SHAPE_W) ? FB + 1 : ccpe_pkg::SHAPE_W;
  localparam int OW   = ccpe_pkg::OUT_W;
  localparam int PW   = 3 * CB;
  localparam logic [TW-1:0] F_ONE = {1'b1, {FB{1'b0}}};

  // configuration registers
  logic [ccpe_pkg::CFG_W-1:0]   start_r, shoulder_r, end_r;
  logic [ccpe_pkg::SHAPE_W-1:0] shape_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      shoulder_r <= '0;
      end_r      <= '0;
      shape_r    <= ccpe_pkg::SHAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccpe_pkg::REG_START:    start_r    <= cfg_data;
        ccpe_pkg::REG_SHOULDER: shoulder_r <= cfg_data;
        ccpe_pkg::REG_END:      end_r      <= cfg_data;
        ccpe_pkg::REG_SHAPE:    shape_r    <= cfg_data[ccpe_pkg::SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // shape constants: f clamped to [1, F-1], g = F-f, k = 2f-F
  logic [CFW-1:0]       shape_ext;
  logic [FB-1:0]        f_nxt, f_r, g_nxt, g_r;
  logic signed [FB+1:0] k_nxt, k_r;

  always_comb begin
    shape_ext = CFW'(shape_r);
    if (shape_r == '0) begin
      f_nxt = FB'(1);
    end else if (shape_ext >= (CFW'(1) << FB)) begin
      f_nxt = {FB{1'b1}};
    end else begin
      f_nxt = shape_ext[FB-1:0];
    end
    g_nxt = '0 - f_nxt;
    k_nxt = $signed({1'b0, f_nxt, 1'b0}) - $signed({2'b01, {FB{1'b0}}});
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  // points padded or trimmed to three coordinate fields
  logic [PW-1:0] start_p, shoulder_p, end_p;
  assign start_p    = PW'(start_r);
  assign shoulder_p = PW'(shoulder_r);
  assign end_p      = PW'(end_r);

  // per-axis constants: A, C-A, 2B-A-C
  logic signed [CB-1:0] a_r  [3];
  logic signed [CB:0]   dl_r [3];
  logic signed [CB+1:0] db_r [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_pts
    logic [CB-1:0] pa, pb, pc;
    assign pa = start_p[ax*CB +: CB];
    assign pb = shoulder_p[ax*CB +: CB];
    assign pc = end_p[ax*CB +: CB];
    always_ff @(posedge clk) begin
      a_r[ax]  <= pa;
      dl_r[ax] <= {pc[CB-1], pc} - {pa[CB-1], pa};
      db_r[ax] <= {pb[CB-1], pb, 1'b0} - {{2{pa[CB-1]}}, pa} - {{2{pc[CB-1]}}, pc};
    end
  end

  // pipeline advances unless a result is parked in the skid register
  logic en;
  logic sf_r;
  assign en       = ~sf_r;
  assign in_stall = sf_r;

  // stage 0: clamp t
  logic          v0_r;
  logic [TW-1:0] t0_r, t_cl;
  assign t_cl = (in_param_t > F_ONE) ? F_ONE : in_param_t;

  // stage 1: u2 = floor(u^2/F)
  logic              v1_r;
  logic [TW-1:0]     t1_r, u2_1_r;
  logic [FB+1:0]     u_w;
  logic [TW-1:0]     au;
  logic [2*FB+1:0]   sq;

  always_comb begin
    u_w = {t0_r, 1'b0} - {2'b01, {FB{1'b0}}};
    au  = u_w[FB+1] ? TW'('0 - u_w) : u_w[TW-1:0];
    sq  = au * au;
  end

  // stage 2: g^2, (2f-F)*u2, u2*f
  logic                  v2_r;
  logic [TW-1:0]         t2_r;
  logic [NUMW-1:0]       gg_r;
  logic signed [2*FB+3:0] pr_nxt, pr_r;
  logic [2*FB:0]         num_full;
  logic [NUMW-1:0]       num2_r;

  always_comb begin
    pr_nxt   = k_r * $signed({1'b0, u2_1_r});
    num_full = u2_1_r * f_r;
  end

  // stage 3: radicand, clamped at zero
  logic                   v3_r;
  logic [TW-1:0]          t3_r;
  logic [NUMW-1:0]        num3_r;
  logic signed [2*FB+3:0] rad_s;
  logic [RW-1:0]          rad_r;
  assign rad_s = $signed({4'b0000, gg_r}) + pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r   <= t_cl;
      t1_r   <= t0_r;
      u2_1_r <= sq[2*FB:FB];
      t2_r   <= t1_r;
      gg_r   <= g_r * g_r;
      pr_r   <= pr_nxt;
      num2_r <= num_full[NUMW-1:0];
      t3_r   <= t2_r;
      num3_r <= num2_r;
      rad_r  <= rad_s[2*FB+3] ? '0 : rad_s[RW-1:0];
    end
  end

  // square root chain, one result bit per cell, MSB first
  logic           sq_v    [FB+2];
  logic [RW-1:0]  sq_rem  [FB+2];
  logic [TW-1:0]  sq_root [FB+2];
  logic [SQS-1:0] sq_side [FB+2];

  assign sq_v[0]    = v3_r;
  assign sq_rem[0]  = rad_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = {t3_r, num3_r};

  for (genvar i = 0; i <= FB; i++) begin : g_sqrt
    ccpe_sqrt_cell #(.FB(FB), .STEP(FB - i), .SIDE_W(SQS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .v_o    (sq_v[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // denominator g + s, dividend u2*f
  logic          vd_r;
  logic [TW-1:0] td_r;
  logic [RW-1:0] remd_r;
  logic [DW-1:0] dend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= sq_v[FB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td_r   <= sq_side[FB+1][SQS-1:NUMW];
      remd_r <= RW'(sq_side[FB+1][NUMW-1:0]);
      dend_r <= {2'b00, g_r} + {1'b0, sq_root[FB+1]};
    end
  end

  // divider chain, one quotient bit per cell
  logic          dv_v   [FB+2];
  logic [RW-1:0] dv_rem [FB+2];
  logic [DW-1:0] dv_den [FB+2];
  logic [QW-1:0] dv_q   [FB+2];
  logic [TW-1:0] dv_t   [FB+2];

  assign dv_v[0]   = vd_r;
  assign dv_rem[0] = remd_r;
  assign dv_den[0] = dend_r;
  assign dv_q[0]   = '0;
  assign dv_t[0]   = td_r;

  for (genvar i = 0; i <= FB; i++) begin : g_div
    ccpe_div_cell #(.FB(FB), .STEP(FB - i), .SIDE_W(TW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[i]),
      .rem_i  (dv_rem[i]),
      .den_i  (dv_den[i]),
      .q_i    (dv_q[i]),
      .side_i (dv_t[i]),
      .v_o    (dv_v[i+1]),
      .rem_o  (dv_rem[i+1]),
      .den_o  (dv_den[i+1]),
      .q_o    (dv_q[i+1]),
      .side_o (dv_t[i+1])
    );
  end

  // y0 = f - quotient
  logic                 vy_r;
  logic [TW-1:0]        ty_r;
  logic signed [YW-1:0] y0_r;

  // axis pipeline valid bits
  logic va1_r, va2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vy_r  <= 1'b0;
      va1_r <= 1'b0;
      va2_r <= 1'b0;
    end else if (en) begin
      vy_r  <= dv_v[FB+1];
      va1_r <= vy_r;
      va2_r <= va1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ty_r <= dv_t[FB+1];
      y0_r <= $signed({2'b00, f_r}) - $signed({1'b0, dv_q[FB+1]});
    end
  end

  logic [OW-1:0] pt_val [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    ccpe_axis #(.CB(CB), .FB(FB)) u_axis (
      .clk   (clk),
      .en    (en),
      .t_i   (ty_r),
      .y0_i  (y0_r),
      .a_i   (a_r[ax]),
      .dl_i  (dl_r[ax]),
      .db_i  (db_r[ax]),
      .val_o (pt_val[ax])
    );
  end

  // output register with one skid entry
  logic          ov_r, take;
  logic [OW-1:0] ox_r, oy_r, oz_r, sx_r, sy_r, sz_r;
  assign take = ov_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sf_r <= 1'b0;
    end else if (sf_r) begin
      if (take) begin
        sf_r <= 1'b0;
      end
    end else if (~ov_r | take) begin
      ov_r <= va2_r;
    end else if (va2_r) begin
      sf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sf_r) begin
      if (take) begin
        ox_r <= sx_r;
        oy_r <= sy_r;
        oz_r <= sz_r;
      end
    end else if (~ov_r | take) begin
      ox_r <= pt_val[0];
      oy_r <= pt_val[1];
      oz_r <= pt_val[2];
    end else begin
      sx_r <= pt_val[0];
      sy_r <= pt_val[1];
      sz_r <= pt_val[2];
    end
  end

  assign out_valid = ov_r;
  assign out_x_out = ox_r;
  assign out_y_out = oy_r;
  assign out_z_out = oz_r;

endmodule

[tb/conic_curve_point_evaluator_test.sv]
module conic_curve_point_evaluator_test;

  localparam int FRAC  = 16;
  localparam int TW    = FRAC + 1;
  localparam int CB    = 20;
  localparam longint ONE = 64'sd65536;
  localparam int LATENCY = 2 * FRAC + 11;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [ccpe_pkg::OUT_W-1:0] x;
    logic [ccpe_pkg::OUT_W-1:0] y;
    logic [ccpe_pkg::OUT_W-1:0] z;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FRAC:0] in_param_t;
  logic out_valid;
  logic out_stall;
  logic [ccpe_pkg::OUT_W-1:0] out_x_out, out_y_out, out_z_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [ccpe_pkg::IDX_W-1:0] cfg_index;
  logic [ccpe_pkg::CFG_W-1:0] cfg_data;

  // shadow copy of the register file
  logic [ccpe_pkg::CFG_W-1:0] arc_start, arc_shoulder, arc_end;
  logic [ccpe_pkg::SHAPE_W-1:0] arc_shape;

  curve_point_t pending_points[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int mismatches;
  int quiet_cycles;

  conic_curve_point_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_param_t(in_param_t),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_out(out_x_out), .out_y_out(out_y_out), .out_z_out(out_z_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint axis_coord(input logic [ccpe_pkg::CFG_W-1:0] packed_pt,
                                        input int k);
    logic signed [CB-1:0] c;
    c = packed_pt[k*CB +: CB];
    return longint'(c);
  endfunction

  function automatic logic [ccpe_pkg::OUT_W-1:0] clip_coord(input longint v);
    if (v > 64'sd2097151) v = 64'sd2097151;
    if (v < -64'sd2097152) v = -64'sd2097152;
    return v[ccpe_pkg::OUT_W-1:0];
  endfunction

  // conic arc point for the current registers
  function automatic curve_point_t conic_point(input logic [FRAC:0] t_in);
    longint f, t, g, u, rad, y0, a, b, c, lin, bend;
    longint unsigned au, u2, s, den, num;
    logic [ccpe_pkg::OUT_W-1:0] axis[3];
    curve_point_t p;
    f = longint'(arc_shape);
    t = longint'(t_in);
    if (f < 1) f = 1;
    if (f > ONE - 1) f = ONE - 1;
    if (t > ONE) t = ONE;
    g = ONE - f;
    u = 2 * t - ONE;
    au = (u < 0) ? -u : u;
    u2 = (au * au) >> FRAC;
    rad = g * g + (2 * f - ONE) * longint'(u2);
    if (rad < 0) rad = 0;
    s = floor_sqrt(rad);
    den = g + s;
    num = u2 * f;
    y0 = f - longint'(num / den);
    for (int k = 0; k < 3; k++) begin
      a = axis_coord(arc_start, k);
      b = axis_coord(arc_shoulder, k);
      c = axis_coord(arc_end, k);
      lin = ((c - a) * t) >>> FRAC;
      bend = ((2 * b - a - c) * y0) >>> (FRAC + 1);
      axis[k] = clip_coord(a + lin + bend);
    end
    p.x = axis[0];
    p.y = axis[1];
    p.z = axis[2];
    return p;
  endfunction

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d", $signed(out_x_out),
                   $signed(out_y_out), $signed(out_z_out));
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_x_out !== exp_pt.x || out_y_out !== exp_pt.y || out_z_out !== exp_pt.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     $signed(exp_pt.x), $signed(exp_pt.y), $signed(exp_pt.z),
                     $signed(out_x_out), $signed(out_y_out), $signed(out_z_out));
        end
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("conic_curve_point_evaluator test failed");
      $finish;
    end
  end

  // one parameter request; valid is left high after acceptance
  task automatic send_param(input logic [FRAC:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_param_t <= t;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(conic_point(t));
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    wait (pending_points.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccpe_pkg::IDX_W-1:0] idx,
                           input logic [ccpe_pkg::CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ccpe_pkg::REG_START:    arc_start = d;
      ccpe_pkg::REG_SHOULDER: arc_shoulder = d;
      ccpe_pkg::REG_END:      arc_end = d;
      ccpe_pkg::REG_SHAPE:    arc_shape = d[ccpe_pkg::SHAPE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_arc(input logic [ccpe_pkg::CFG_W-1:0] a,
                         input logic [ccpe_pkg::CFG_W-1:0] b,
                         input logic [ccpe_pkg::CFG_W-1:0] c,
                         input logic [ccpe_pkg::CFG_W-1:0] f);
    drain();
    write_reg(ccpe_pkg::REG_START, a);
    write_reg(ccpe_pkg::REG_SHOULDER, b);
    write_reg(ccpe_pkg::REG_END, c);
    write_reg(ccpe_pkg::REG_SHAPE, f);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ccpe_pkg::CFG_W-1:0] rand_point();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ccpe_pkg::CFG_W-1:0];
  endfunction

  function automatic logic [ccpe_pkg::CFG_W-1:0] rand_shape();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: r[15:0] = 16'd0;
      1: r[15:0] = 16'hFFFF;
      2: r[15:0] = 16'd1;
      default: ;
    endcase
    return r[ccpe_pkg::CFG_W-1:0];
  endfunction

  function automatic logic [FRAC:0] rand_param();
    case ($urandom_range(9))
      0: return TW'($urandom_range(131071));
      1: return ($urandom_range(1)) ? 17'd0 : 17'd65536;
      default: return TW'($urandom_range(65536));
    endcase
  endfunction

  localparam logic [CB-1:0] C_MAX = 20'h7FFFF;
  localparam logic [CB-1:0] C_MIN = 20'h80000;

  // registers straight after reset
  task automatic test_reset_state();
    send_param(17'd0);
    send_param(17'd32768);
    send_param(17'd65536);
    send_param(17'd131071);
    finish_sending();
  endtask

  // field extremes, shape factor edges, parameter beyond one
  task automatic test_directed();
    logic [FRAC:0] ts[6];
    ts = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd131071};
    set_arc({C_MAX, C_MIN, C_MAX}, {C_MIN, C_MAX, C_MIN}, {C_MIN, C_MAX, C_MAX}, 60'd0);
    foreach (ts[i]) send_param(ts[i]);
    finish_sending();
    set_arc({C_MIN, C_MIN, C_MIN}, {C_MAX, C_MAX, C_MAX}, {C_MIN, C_MIN, C_MIN},
            {44'hFFFFFFFFFFF, 16'hFFFF});
    foreach (ts[i]) send_param(ts[i]);
    finish_sending();
    set_arc({20'd100, -20'sd300, 20'd0}, {20'd5000, 20'd4000, -20'sd7000},
            {-20'sd900, 20'd2500, 20'd6000}, 60'd1);
    foreach (ts[i]) send_param(ts[i]);
    finish_sending();
    set_arc(rand_point(), rand_point(), rand_point(), 60'd32768);
    foreach (ts[i]) send_param(ts[i]);
    finish_sending();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        finish_sending();
        set_arc(rand_point(), rand_point(), rand_point(), rand_shape());
      end
      send_param(rand_param());
    end
    finish_sending();
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_arc(rand_point(), rand_point(), rand_point(), rand_shape());
    hold_off_cycles = 300;
    for (int i = 0; i < 150; i++) send_param(rand_param());
    finish_sending();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_param_t <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= ccpe_pkg::REG_START;
    cfg_data <= '0;
    arc_start = '0;
    arc_shoulder = '0;
    arc_end = '0;
    arc_shape = ccpe_pkg::SHAPE_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_random_phase(0, 0, 250);
    test_random_phase(48, 0, 250);
    test_random_phase(0, 48, 250);
    test_random_phase(15, 15, 250);
    test_backpressure();

    wait (pending_points.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0)
      $display("conic_curve_point_evaluator test passed");
    else
      $display("conic_curve_point_evaluator test failed");
    $finish;
  end

endmodule
